/* src/atpf_pkg.sv */
`timescale 1ns / 1ps

package atpf_pkg;

    localparam int MEMORY_BYTES_DEF = 32768;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int COEF_W     = 13;

    localparam logic [2:0] REG_MATRIX_A    = 3'd0;
    localparam logic [2:0] REG_MATRIX_B    = 3'd1;
    localparam logic [2:0] REG_MATRIX_C    = 3'd2;
    localparam logic [2:0] REG_MATRIX_D    = 3'd3;
    localparam logic [2:0] REG_CENTER_H    = 3'd4;
    localparam logic [2:0] REG_CENTER_V    = 3'd5;
    localparam logic [2:0] REG_REPEAT_MODE = 3'd6;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef struct packed {
        logic        command;
        logic [14:0] mem_address;
        logic [7:0]  mem_byte;
        logic [7:0]  screen_x;
        logic [7:0]  screen_y;
    } t_in_item;

    typedef struct packed {
        logic       opaque;
        logic [7:0] pix_color;
    } t_out_item;

endpackage

/* src/affine_tilemap_pixel_fetch_top.sv */
// Memory write: busy stays low afterwards; the byte is visible to the next transaction.
// Pixel: multiply at accept, then S_SUM (sum, tile read), S_TILE (color read) and
// S_COLOR (result strobe); busy is high through them, one pixel at a time, paced by
// two dependent memory reads. Outside the map with repeat_mode 1, S_SUM strobes a
// zero result, no memory reads. Reset: config registers and the strobe clear, then a
// clearing pass zeroes the memory with busy high; the receiver cannot stall results.
`timescale 1ns / 1ps

module affine_tilemap_pixel_fetch_top #(
    parameter int MEMORY_BYTES = atpf_pkg::MEMORY_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  atpf_pkg::t_in_item                i_item,
    output logic                              o_result_valid,
    output atpf_pkg::t_out_item               o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [atpf_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [atpf_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [atpf_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int AW = $clog2(MEMORY_BYTES);
    localparam logic [16:0] MEM_LIMIT = 17'(MEMORY_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEMORY_BYTES - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SUM   = 6'b000100,
        S_TILE  = 6'b001000,
        S_COLOR = 6'b010000,
        S_SPARE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic signed [atpf_pkg::COEF_W-1:0] r_matrix_a, r_matrix_b, r_matrix_c, r_matrix_d;
    logic signed [atpf_pkg::COEF_W-1:0] r_center_h, r_center_v;
    logic                               r_repeat_mode;

    logic [7:0] mem [MEMORY_BYTES];

    logic [AW-1:0]      r_clr_addr;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [7:0]         mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [7:0]         r_rd_data;

    logic signed [20:0] r_prod_a, r_prod_b, r_prod_c, r_prod_d;
    logic signed [20:0] n_prod_a, n_prod_b, n_prod_c, n_prod_d;
    logic signed [7:0]  w_cx, w_cy;
    logic signed [20:0] w_ch, w_cv;
    logic signed [22:0] w_sum_x, w_sum_y;
    logic        [14:0] w_map_x, w_map_y;
    logic               w_outside;

    logic [5:0]  r_fine, n_fine;
    logic        r_valid, n_valid;
    atpf_pkg::t_out_item r_result, n_result;

    logic        accept;
    logic        cfg_wr;
    logic [16:0] w_addr_ext;
    logic [16:0] w_addr_mod;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_a    <= '0;
            r_matrix_b    <= '0;
            r_matrix_c    <= '0;
            r_matrix_d    <= '0;
            r_center_h    <= '0;
            r_center_v    <= '0;
            r_repeat_mode <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                atpf_pkg::REG_MATRIX_A:    r_matrix_a    <= pwdata[12:0];
                atpf_pkg::REG_MATRIX_B:    r_matrix_b    <= pwdata[12:0];
                atpf_pkg::REG_MATRIX_C:    r_matrix_c    <= pwdata[12:0];
                atpf_pkg::REG_MATRIX_D:    r_matrix_d    <= pwdata[12:0];
                atpf_pkg::REG_CENTER_H:    r_center_h    <= pwdata[12:0];
                atpf_pkg::REG_CENTER_V:    r_center_v    <= pwdata[12:0];
                atpf_pkg::REG_REPEAT_MODE: r_repeat_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            atpf_pkg::REG_MATRIX_A:    prdata = 32'({19'd0, r_matrix_a});
            atpf_pkg::REG_MATRIX_B:    prdata = 32'({19'd0, r_matrix_b});
            atpf_pkg::REG_MATRIX_C:    prdata = 32'({19'd0, r_matrix_c});
            atpf_pkg::REG_MATRIX_D:    prdata = 32'({19'd0, r_matrix_d});
            atpf_pkg::REG_CENTER_H:    prdata = 32'({19'd0, r_center_h});
            atpf_pkg::REG_CENTER_V:    prdata = 32'({19'd0, r_center_v});
            atpf_pkg::REG_REPEAT_MODE: prdata = 32'({31'd0, r_repeat_mode});
            default:                   prdata = '0;
        endcase
    end

    // reduce the write address modulo the memory size; it stays below twice that size
    assign w_addr_ext = {2'b00, i_item.mem_address};
    assign w_addr_mod = (w_addr_ext >= MEM_LIMIT) ? (w_addr_ext - MEM_LIMIT) : w_addr_ext;

    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = 8'h00;
        end else begin
            mem_we    = accept && (i_item.command == atpf_pkg::CMD_WRITE);
            mem_waddr = w_addr_mod[AW-1:0];
            mem_wdata = i_item.mem_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == S_CLEAR) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign w_cx = {~i_item.screen_x[7], i_item.screen_x[6:0]};
    assign w_cy = {~i_item.screen_y[7], i_item.screen_y[6:0]};

    assign n_prod_a = r_matrix_a * w_cx;
    assign n_prod_b = r_matrix_b * w_cy;
    assign n_prod_c = r_matrix_c * w_cx;
    assign n_prod_d = r_matrix_d * w_cy;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod_a <= n_prod_a;
            r_prod_b <= n_prod_b;
            r_prod_c <= n_prod_c;
            r_prod_d <= n_prod_d;
        end
    end

    assign w_ch    = $signed({r_center_h, 8'h00});
    assign w_cv    = $signed({r_center_v, 8'h00});
    assign w_sum_x = 23'(r_prod_a) + 23'(r_prod_b) + 23'(w_ch);
    assign w_sum_y = 23'(r_prod_c) + 23'(r_prod_d) + 23'(w_cv);
    assign w_map_x = w_sum_x[22:8];
    assign w_map_y = w_sum_y[22:8];
    assign w_outside = (|w_map_x[14:9]) || (|w_map_y[14:9]);

    always_comb begin
        n_state  = r_state;
        n_fine   = r_fine;
        n_valid  = 1'b0;
        n_result = r_result;
        mem_re   = 1'b0;
        mem_raddr = '0;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && (i_item.command == atpf_pkg::CMD_PIXEL)) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (w_outside && r_repeat_mode) begin
                    n_valid  = 1'b1;
                    n_result = '0;
                    n_state  = S_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'({w_map_y[8:3], w_map_x[8:3]});
                    n_fine    = {w_map_y[2:0], w_map_x[2:0]};
                    n_state   = S_TILE;
                end
            end
            S_TILE: begin
                mem_re    = 1'b1;
                mem_raddr = AW'({r_rd_data, r_fine});
                n_state   = S_COLOR;
            end
            S_COLOR: begin
                n_valid            = 1'b1;
                n_result.opaque    = (r_rd_data != 8'h00);
                n_result.pix_color = r_rd_data;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fine   <= n_fine;
        r_result <= n_result;
    end

    assign o_result_valid = r_valid;
    assign o_result       = r_result;

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == S_COLOR || $past(r_state) == S_SUM))
        else $error("result strobe without a finished pixel");

    a_opaque_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.opaque == (o_result.pix_color != 8'h00)))
        else $error("opaque flag disagrees with pixel color");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("two result strobes in a row");

    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.command == atpf_pkg::CMD_PIXEL)) |=> busy)
        else $error("pixel transaction did not raise busy");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.command == atpf_pkg::CMD_WRITE)) |=> !busy)
        else $error("memory write transaction left the block busy");

endmodule
